/* hw/rtl/pulse_width_card_reader_top_macros.svh */
// assertion macros shared by the card reader modules
// each macro expects clk and rst_n in scope
`ifndef PULSE_WIDTH_CARD_READER_TOP_MACROS_SVH
`define PULSE_WIDTH_CARD_READER_TOP_MACROS_SVH

// same-cycle implication
`define PWCR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PWCR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/pwcr_pkg.sv */
// ----------------------------------------------------------------------------
// pwcr_pkg
// Types and constants shared by the pulse width card reader modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pwcr_pkg;

    localparam int TIME_W   = 16;
    localparam int MEMBER_W = 24;
    localparam int SKIP_W   = 3;
    localparam int TICK_W   = 8;
    localparam int IDX_W    = 5;
    localparam int PERSON_W = 16;
    localparam int CARD_BITS = 24;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [IDX_W-1:0]  CARD_BITS_IDX = IDX_W'(CARD_BITS);
    localparam logic [IDX_W-1:0]  MEMBER_W_IDX  = IDX_W'(MEMBER_W);

    // command codes
    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // register indexes (word address)
    localparam logic [1:0] REG_MEMBER_CARD  = 2'd0;
    localparam logic [1:0] REG_EDGE_SKIP    = 2'd1;
    localparam logic [1:0] REG_UNLOCK_TICKS = 2'd2;

    // reset values
    localparam logic [MEMBER_W-1:0] MEMBER_RESET    = '0;
    localparam logic [SKIP_W-1:0]   EDGE_SKIP_RESET = 3'd4;
    localparam logic [TICK_W-1:0]   TICKS_RESET     = 8'd15;
    localparam logic [SKIP_W-1:0]   SKIP_CNT_RESET  = 3'd2;
    localparam logic [TICK_W-1:0]   COUNTDOWN_RESET = 8'd15;
    localparam logic [PERSON_W-1:0] PERSONS_RESET   = 16'd4;

    typedef struct packed {
        logic              command;
        logic [TIME_W-1:0] capture_time;
    } item_t;

    typedef struct packed {
        logic                unlock;
        logic                card_done;
        logic                card_accepted;
        logic [PERSON_W-1:0] person_count;
    } result_t;

    typedef struct packed {
        logic [MEMBER_W-1:0] member_card;
        logic [SKIP_W-1:0]   edge_skip_after_card;
        logic [TICK_W-1:0]   unlock_ticks;
    } cfg_t;

    typedef struct packed {
        logic done;
        logic accepted;
    } card_evt_t;

endpackage

`default_nettype wire

/* hw/rtl/pwcr_regs.sv */
// ----------------------------------------------------------------------------
// pwcr_regs
// APB configuration registers: member card, edge skip, unlock ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module pwcr_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pwcr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [pwcr_pkg::DATA_W-1:0] pwdata,
    output logic      [pwcr_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output pwcr_pkg::cfg_t                   cfg
);

    logic [pwcr_pkg::MEMBER_W-1:0] member_reg;
    logic [pwcr_pkg::SKIP_W-1:0]   skip_reg;
    logic [pwcr_pkg::TICK_W-1:0]   ticks_reg;
    logic                          wr_en;
    logic [1:0]                    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            member_reg <= pwcr_pkg::MEMBER_RESET;
            skip_reg   <= pwcr_pkg::EDGE_SKIP_RESET;
            ticks_reg  <= pwcr_pkg::TICKS_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                pwcr_pkg::REG_MEMBER_CARD:  member_reg <= pwdata[pwcr_pkg::MEMBER_W-1:0];
                pwcr_pkg::REG_EDGE_SKIP:    skip_reg   <= pwdata[pwcr_pkg::SKIP_W-1:0];
                pwcr_pkg::REG_UNLOCK_TICKS: ticks_reg  <= pwdata[pwcr_pkg::TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            pwcr_pkg::REG_MEMBER_CARD:  prdata = pwcr_pkg::DATA_W'(member_reg);
            pwcr_pkg::REG_EDGE_SKIP:    prdata = pwcr_pkg::DATA_W'(skip_reg);
            pwcr_pkg::REG_UNLOCK_TICKS: prdata = pwcr_pkg::DATA_W'(ticks_reg);
            default:                    prdata = '0;
        endcase
    end

    assign cfg.member_card          = member_reg;
    assign cfg.edge_skip_after_card = skip_reg;
    assign cfg.unlock_ticks         = ticks_reg;

endmodule

`default_nettype wire

/* hw/rtl/pwcr_decode.sv */
// ----------------------------------------------------------------------------
// pwcr_decode
// Edge skipping, narrow/wide interval measurement and card bit matching.
// ----------------------------------------------------------------------------
`default_nettype none

module pwcr_decode (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        step,
    input  wire logic [pwcr_pkg::TIME_W-1:0] capture_time,
    input  wire pwcr_pkg::cfg_t              cfg,
    output pwcr_pkg::card_evt_t              evt
);

    `include "pulse_width_card_reader_top_macros.svh"

    logic [pwcr_pkg::SKIP_W-1:0] skip_reg, skip_next;
    logic                        expect_reg, expect_next;
    logic                        first_reg, first_next;
    logic [pwcr_pkg::TIME_W-1:0] stamp_a_reg, stamp_a_next;
    logic [pwcr_pkg::TIME_W-1:0] stamp_b_reg, stamp_b_next;
    logic [pwcr_pkg::TIME_W-1:0] narrow_reg, narrow_next;
    logic [pwcr_pkg::IDX_W-1:0]  bit_index_reg, bit_index_next;
    logic [pwcr_pkg::IDX_W-1:0]  match_reg, match_next;

    logic [pwcr_pkg::TIME_W-1:0] wide;
    logic                        decoded;
    logic                        want;
    logic [pwcr_pkg::IDX_W-1:0]  idx_inc;
    logic [pwcr_pkg::IDX_W-1:0]  match_inc;

    assign wide      = capture_time - stamp_b_reg;
    assign decoded   = wide > narrow_reg;
    // member bits above the register read as zero
    assign want      = (bit_index_reg < pwcr_pkg::MEMBER_W_IDX) ?
                       cfg.member_card[bit_index_reg] : 1'b0;
    assign idx_inc   = bit_index_reg + 1'b1;
    assign match_inc = (decoded == want) ? match_reg + 1'b1 : match_reg;

    always_comb
    begin
        skip_next      = skip_reg;
        expect_next    = expect_reg;
        first_next     = first_reg;
        stamp_a_next   = stamp_a_reg;
        stamp_b_next   = stamp_b_reg;
        narrow_next    = narrow_reg;
        bit_index_next = bit_index_reg;
        match_next     = match_reg;
        evt            = '0;
        if (step)
        begin
            if (skip_reg != '0)
            begin
                skip_next = skip_reg - 1'b1;
            end
            else if (expect_reg)
            begin
                // second kind: narrow interval
                stamp_b_next = capture_time;
                expect_next  = 1'b0;
                first_next   = 1'b0;
                narrow_next  = capture_time - stamp_a_reg;
            end
            else
            begin
                stamp_a_next = capture_time;
                expect_next  = 1'b1;
                if (!first_reg)
                begin
                    bit_index_next = idx_inc;
                    match_next     = match_inc;
                    if (idx_inc >= pwcr_pkg::CARD_BITS_IDX)
                    begin
                        evt.done       = 1'b1;
                        evt.accepted   = (match_inc == pwcr_pkg::CARD_BITS_IDX);
                        first_next     = 1'b1;
                        bit_index_next = '0;
                        match_next     = '0;
                        skip_next      = cfg.edge_skip_after_card;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg      <= pwcr_pkg::SKIP_CNT_RESET;
            expect_reg    <= 1'b0;
            first_reg     <= 1'b1;
            stamp_a_reg   <= '0;
            stamp_b_reg   <= '0;
            narrow_reg    <= '0;
            bit_index_reg <= '0;
            match_reg     <= '0;
        end
        else
        begin
            skip_reg      <= skip_next;
            expect_reg    <= expect_next;
            first_reg     <= first_next;
            stamp_a_reg   <= stamp_a_next;
            stamp_b_reg   <= stamp_b_next;
            narrow_reg    <= narrow_next;
            bit_index_reg <= bit_index_next;
            match_reg     <= match_next;
        end
    end

    `PWCR_ASSERT_NOW(a_idx_range, 1'b1, bit_index_reg < pwcr_pkg::CARD_BITS_IDX,
        "bit index past card length")
    `PWCR_ASSERT_NOW(a_match_le_idx, 1'b1, match_reg <= bit_index_reg,
        "more matches than decoded bits")
    `PWCR_ASSERT_NEXT(a_done_resets, evt.done, first_reg && bit_index_reg == '0 && match_reg == '0,
        "card state not cleared after card read")

endmodule

`default_nettype wire

/* hw/rtl/pwcr_lock.sv */
// ----------------------------------------------------------------------------
// pwcr_lock
// Unlock level, tick countdown and person count.
// ----------------------------------------------------------------------------
`default_nettype none

module pwcr_lock (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          tick,
    input  wire pwcr_pkg::card_evt_t           evt,
    input  wire logic [pwcr_pkg::TICK_W-1:0]   unlock_ticks,
    output logic                               unlock,
    output logic      [pwcr_pkg::PERSON_W-1:0] person_count
);

    `include "pulse_width_card_reader_top_macros.svh"

    logic                          armed_reg, armed_next;
    logic [pwcr_pkg::TICK_W-1:0]   count_reg, count_next;
    logic [pwcr_pkg::PERSON_W-1:0] persons_reg, persons_next;
    logic [pwcr_pkg::TICK_W-1:0]   count_dec;

    assign count_dec = count_reg - 1'b1;

    always_comb
    begin
        armed_next   = armed_reg;
        count_next   = count_reg;
        persons_next = persons_reg;
        if (tick && armed_reg)
        begin
            count_next = count_dec;
            if (count_dec == '0)
            begin
                armed_next = 1'b0;
                count_next = unlock_ticks;
            end
        end
        else if (evt.accepted)
        begin
            // a match while open reloads and counts again
            armed_next   = 1'b1;
            count_next   = unlock_ticks;
            persons_next = persons_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg   <= 1'b0;
            count_reg   <= pwcr_pkg::COUNTDOWN_RESET;
            persons_reg <= pwcr_pkg::PERSONS_RESET;
        end
        else
        begin
            armed_reg   <= armed_next;
            count_reg   <= count_next;
            persons_reg <= persons_next;
        end
    end

    assign unlock       = armed_next;
    assign person_count = persons_next;

    `PWCR_ASSERT_NEXT(a_person_inc, evt.accepted && !tick,
        persons_reg == $past(persons_reg) + 1'b1 && armed_reg, "accepted card not counted")
    `PWCR_ASSERT_NEXT(a_locked_tick, tick && !armed_reg,
        !armed_reg && $stable(count_reg), "tick changed a closed lock")

endmodule

`default_nettype wire

/* hw/rtl/pulse_width_card_reader_top.sv */
// ----------------------------------------------------------------------------
// pulse_width_card_reader_top
// Pulse width card reader with door unlock and person counter.
// ----------------------------------------------------------------------------
// Takes one item per clock: an item is captured in an input register, decoded
// by one pass of short logic against the edge and lock state, and its result
// lands in the result register; a new item can enter the input register while
// the last one moves on, so the sustained rate is one item per cycle, limited
// only by the result register being taken. Configuration is written over APB
// at byte addresses 0 (member card), 4 (edge skip after card) and 8 (unlock
// ticks); write it only while no item is in flight.
`default_nettype none

module pulse_width_card_reader_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        item_valid,
    output logic                             item_ready,
    input  wire pwcr_pkg::item_t             item,
    output logic                             result_valid,
    input  wire logic                        result_ready,
    output pwcr_pkg::result_t                result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pwcr_pkg::ADDR_W-1:0] paddr,
    input  wire logic [pwcr_pkg::DATA_W-1:0] pwdata,
    output logic      [pwcr_pkg::DATA_W-1:0] prdata,
    output logic                             pready
);

    `include "pulse_width_card_reader_top_macros.svh"

    pwcr_pkg::cfg_t      cfg;
    pwcr_pkg::card_evt_t evt;
    pwcr_pkg::item_t     in_reg;
    pwcr_pkg::result_t   out_reg, out_next;
    logic                in_valid_reg;
    logic                out_valid_reg;
    logic                advance;
    logic                fire;
    logic                unlock_nx;
    logic [pwcr_pkg::PERSON_W-1:0] persons_nx;

    assign advance    = !out_valid_reg || result_ready;
    assign fire       = in_valid_reg && advance;
    assign item_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                in_valid_reg <= item_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_reg <= item;
        end
        if (fire)
        begin
            out_reg <= out_next;
        end
    end

    pwcr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pwcr_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (fire && in_reg.command == pwcr_pkg::CMD_EDGE),
        .capture_time (in_reg.capture_time),
        .cfg          (cfg),
        .evt          (evt)
    );

    pwcr_lock u_lock (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick         (fire && in_reg.command == pwcr_pkg::CMD_TICK),
        .evt          (evt),
        .unlock_ticks (cfg.unlock_ticks),
        .unlock       (unlock_nx),
        .person_count (persons_nx)
    );

    always_comb
    begin
        out_next.unlock        = unlock_nx;
        out_next.card_done     = evt.done;
        out_next.card_accepted = evt.accepted;
        out_next.person_count  = persons_nx;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    `PWCR_ASSERT_NOW(a_acc_done, out_valid_reg && out_reg.card_accepted,
        out_reg.card_done && out_reg.unlock, "accepted card without done or unlock")
    `PWCR_ASSERT_NEXT(a_fire_loads, fire,
        out_valid_reg, "processed item produced no result")

endmodule

`default_nettype wire
